@@ sv/longest_valid_bracket_run_top_defines.svh @@
// ----------------------------------------------------------------------------
// Longest valid bracket run: assertion macros
// Concurrent checks on clk, with and without reset masking.
// ----------------------------------------------------------------------------
`ifndef LONGEST_VALID_BRACKET_RUN_TOP_DEFINES_SVH
`define LONGEST_VALID_BRACKET_RUN_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define LVBR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lvbr assertion failed");

`define LVBR_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("lvbr assertion failed");

`else

`define LVBR_ASSERT(label, prop)

`define LVBR_ASSERT_ALWAYS(label, prop)

`endif

`endif

@@ sv/lvbr_pkg.sv @@
// ----------------------------------------------------------------------------
// lvbr_pkg
// Shared types and constants of the longest valid bracket run block.
// ----------------------------------------------------------------------------
`default_nettype none

package lvbr_pkg;

  localparam int MAX_LEN_DEF = 4096;
  localparam int SYM_W       = 8;
  localparam int LEN_W       = 13;

  localparam logic [SYM_W-1:0] OPEN_SYMBOL = 8'h28;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } sym_t;

  typedef struct packed {
    logic [LEN_W-1:0] longest_length;
    logic             overflow;
  } res_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

endpackage

`default_nettype wire

@@ sv/lvbr_cell.sv @@
// ----------------------------------------------------------------------------
// lvbr_cell
// One stack entry: takes its upper neighbor on push, its lower one on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module lvbr_cell #(
  parameter int W = 12
) (
  input  wire                      clk,
  input  wire lvbr_pkg::stk_ctrl_t ctrl,
  input  wire  [W-1:0]             up_value,
  input  wire  [W-1:0]             down_value,
  output logic [W-1:0]             value
);

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      value <= up_value;
    end else if (ctrl.pop) begin
      value <= down_value;
    end
  end

endmodule

`default_nettype wire

@@ sv/lvbr_stack.sv @@
// ----------------------------------------------------------------------------
// lvbr_stack
// Shift stack of open positions built as a row of cells; cell 0 is the top.
// ----------------------------------------------------------------------------
`default_nettype none

module lvbr_stack #(
  parameter int DEPTH = 4096,
  parameter int W     = 12
) (
  input  wire                      clk,
  input  wire lvbr_pkg::stk_ctrl_t ctrl,
  input  wire  [W-1:0]             push_data,
  output logic [W-1:0]             second
);

  logic [W-1:0] cell_value [DEPTH];
  logic [W-1:0] up_in      [DEPTH];
  logic [W-1:0] down_in    [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_top
      assign up_in[i] = push_data;
    end else begin : g_mid
      assign up_in[i] = cell_value[i-1];
    end
    if (i == DEPTH - 1) begin : g_bot
      assign down_in[i] = cell_value[i];
    end else begin : g_nbot
      assign down_in[i] = cell_value[i+1];
    end

    lvbr_cell #(
      .W(W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .up_value   (up_in[i]),
      .down_value (down_in[i]),
      .value      (cell_value[i])
    );
  end

  assign second = cell_value[1];

endmodule

`default_nettype wire

@@ sv/longest_valid_bracket_run_top.sv @@
// A result is registered and appears in the cycle after the transaction marked last.
// Throughput: 1 byte per cycle while not stalled; all cells of the row push or pop together
//   and the run length is one subtract and compare.
// Input stalls only while a held result is stalled downstream.
// Reset (rst, synchronous) clears counters, barrier, best length, flag and
//   res_valid; stack cells and res_data hold stale data and are never read unset.
// ----------------------------------------------------------------------------
// longest_valid_bracket_run_top
// Longest matched bracket substring of a byte string, one byte per cycle while not stalled.
// ----------------------------------------------------------------------------
`default_nettype none
`include "longest_valid_bracket_run_top_defines.svh"

module longest_valid_bracket_run_top #(
  parameter int MAX_LEN = lvbr_pkg::MAX_LEN_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 sym_valid,
  output logic                sym_stall,
  input  wire lvbr_pkg::sym_t sym_data,
  output logic                res_valid,
  input  wire                 res_stall,
  output lvbr_pkg::res_t      res_data
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int POS_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [CNT_W-1:0] position;
  logic [CNT_W-1:0] stack_count;
  logic [CNT_W-1:0] barrier;
  logic [CNT_W-1:0] best_length;
  logic             overflowed;

  logic [CNT_W-1:0] position_next;
  logic [CNT_W-1:0] stack_count_next;
  logic [CNT_W-1:0] barrier_next;
  logic [CNT_W-1:0] best_length_next;
  logic             overflowed_next;
  logic [CNT_W-1:0] run;

  logic                sym_accept;
  logic                full;
  logic                is_open;
  lvbr_pkg::stk_ctrl_t stk_ctrl;
  logic [POS_W-1:0]    stk_second;

  assign sym_stall  = res_valid && res_stall;
  assign sym_accept = sym_valid && !sym_stall;
  assign full       = (position == CNT_W'(MAX_LEN));
  assign is_open    = (sym_data.symbol == lvbr_pkg::OPEN_SYMBOL);

  assign stk_ctrl.push = sym_accept && !full && is_open;
  assign stk_ctrl.pop  = sym_accept && !full && !is_open && (stack_count != '0);

  lvbr_stack #(
    .DEPTH(MAX_LEN),
    .W    (POS_W)
  ) u_stack (
    .clk       (clk),
    .ctrl      (stk_ctrl),
    .push_data (position[POS_W-1:0]),
    .second    (stk_second)
  );

  always_comb begin
    if (stack_count == CNT_W'(1)) begin
      run = position + CNT_W'(1) - barrier;
    end else begin
      run = position - CNT_W'(stk_second);
    end
  end

  always_comb begin
    position_next    = position;
    stack_count_next = stack_count;
    barrier_next     = barrier;
    best_length_next = best_length;
    overflowed_next  = overflowed;
    if (sym_accept) begin
      if (full) begin
        overflowed_next = 1'b1;
      end else begin
        position_next = position + CNT_W'(1);
        if (is_open) begin
          stack_count_next = stack_count + CNT_W'(1);
        end else if (stack_count == '0) begin
          barrier_next = position + CNT_W'(1);
        end else begin
          stack_count_next = stack_count - CNT_W'(1);
          if (run > best_length) begin
            best_length_next = run;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      stack_count <= '0;
      barrier     <= '0;
      best_length <= '0;
      overflowed  <= 1'b0;
    end else if (sym_accept && sym_data.last) begin
      position    <= '0;
      stack_count <= '0;
      barrier     <= '0;
      best_length <= '0;
      overflowed  <= 1'b0;
    end else begin
      position    <= position_next;
      stack_count <= stack_count_next;
      barrier     <= barrier_next;
      best_length <= best_length_next;
      overflowed  <= overflowed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (sym_accept && sym_data.last) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sym_accept && sym_data.last) begin
      res_data.longest_length <= lvbr_pkg::LEN_W'(best_length_next);
      res_data.overflow       <= overflowed_next;
    end
  end

  `LVBR_ASSERT(a_count_le_position, stack_count <= position)
  `LVBR_ASSERT(a_barrier_le_position, barrier <= position)
  `LVBR_ASSERT(a_result_from_last, $rose(res_valid) |-> $past(sym_accept && sym_data.last))
  `LVBR_ASSERT(a_clear_after_last, (sym_accept && sym_data.last) |=> (position == '0))
  `LVBR_ASSERT_ALWAYS(a_no_push_pop, !(stk_ctrl.push && stk_ctrl.pop))

endmodule

`default_nettype wire

@@ sim/lvbr_checker.sv @@
// ----------------------------------------------------------------------------
// lvbr_checker
// Watches the byte and result channels of the bracket run block, keeps its
// own bracket scanner to predict each per-string report and compares every
// result transaction with the oldest predicted report, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lvbr_checker #(
  parameter int MAX_LEN = lvbr_pkg::MAX_LEN_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 sym_valid,
  input  wire                 sym_stall,
  input  wire lvbr_pkg::sym_t sym_data,
  input  wire                 res_valid,
  input  wire                 res_stall,
  input  wire lvbr_pkg::res_t res_data,
  output int                  errors,
  output int                  pending
);

  localparam int MAX_PRINTED = 20;

  logic [lvbr_pkg::LEN_W-2:0] open_pos [MAX_LEN];
  logic [lvbr_pkg::LEN_W-1:0] open_count;
  logic [lvbr_pkg::LEN_W-1:0] next_pos;
  logic [lvbr_pkg::LEN_W-1:0] barrier;
  logic [lvbr_pkg::LEN_W-1:0] best_run;
  logic                       overflowed;
  lvbr_pkg::res_t             expected_reports [$];

  task automatic clear_scan();
    open_count = '0;
    next_pos   = '0;
    barrier    = '0;
    best_run   = '0;
    overflowed = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < MAX_PRINTED) begin
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
    errors++;
  endtask

  // Match each close with the nearest pending open; a lone close moves the barrier.
  task automatic scan_byte(input lvbr_pkg::sym_t item);
    logic [lvbr_pkg::LEN_W-1:0] run;
    lvbr_pkg::res_t             report;
    if (next_pos >= MAX_LEN) begin
      overflowed = 1'b1;
    end else begin
      if (item.symbol == lvbr_pkg::OPEN_SYMBOL) begin
        if (open_count < MAX_LEN) begin
          open_pos[open_count[lvbr_pkg::LEN_W-2:0]] = next_pos[lvbr_pkg::LEN_W-2:0];
          open_count++;
        end
      end else if (open_count == 0) begin
        barrier = next_pos + 1'b1;
      end else begin
        open_count--;
        if (open_count == 0) begin
          run = next_pos + 1'b1 - barrier;
        end else begin
          run = next_pos - {1'b0,
                open_pos[(lvbr_pkg::LEN_W-1)'(open_count - 1'b1)]};
        end
        if (run > best_run) begin
          best_run = run;
        end
      end
      next_pos++;
    end
    if (item.last) begin
      report.longest_length = best_run;
      report.overflow       = overflowed;
      expected_reports.push_back(report);
      clear_scan();
    end
  endtask

  always @(posedge clk) begin
    lvbr_pkg::res_t want;
    if (rst) begin
      clear_scan();
      expected_reports.delete();
      errors = 0;
    end else begin
      if (sym_valid && !sym_stall) begin
        scan_byte(sym_data);
      end
      if (res_valid && !res_stall) begin
        if (expected_reports.size() == 0) begin
          report_mismatch("result with no report pending", res_data.longest_length, 0);
        end else begin
          want = expected_reports.pop_front();
          if (res_data.longest_length !== want.longest_length) begin
            report_mismatch("longest_length", res_data.longest_length, want.longest_length);
          end
          if (res_data.overflow !== want.overflow) begin
            report_mismatch("overflow", res_data.overflow, want.overflow);
          end
        end
      end
    end
    pending <= expected_reports.size();
  end

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Feeds bracket strings to the longest valid bracket run block: a directed
// set of short strings, then random strings (mostly nested bracket runs with
// stray closes, some raw byte noise). Sender and receiver idle at random in
// the directed set and two of three random phases; the last never idles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

  localparam int MAX_LEN      = lvbr_pkg::MAX_LEN_DEF;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_BYTES  = 220;
  localparam int SETTLE_CYCLES = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sym_valid = 1'b0;
  lvbr_pkg::sym_t sym_data = '0;
  logic sym_stall;
  logic res_valid;
  logic res_stall = 1'b0;
  lvbr_pkg::res_t res_data;

  int errors;
  int pending;
  int cycles = 0;
  int bytes_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  longest_valid_bracket_run_top #(
    .MAX_LEN(MAX_LEN)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .sym_valid(sym_valid),
    .sym_stall(sym_stall),
    .sym_data(sym_data),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data(res_data)
  );

  lvbr_checker #(
    .MAX_LEN(MAX_LEN)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .sym_valid(sym_valid),
    .sym_stall(sym_stall),
    .sym_data(sym_data),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data(res_data),
    .errors(errors),
    .pending(pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    res_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [lvbr_pkg::SYM_W-1:0] close_symbol();
    logic [lvbr_pkg::SYM_W-1:0] s;
    s = lvbr_pkg::SYM_W'($urandom_range(255));
    if (s == lvbr_pkg::OPEN_SYMBOL) begin
      s = ~lvbr_pkg::OPEN_SYMBOL;
    end
    return s;
  endfunction

  task automatic send_byte(input logic [lvbr_pkg::SYM_W-1:0] s, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      sym_valid <= 1'b0;
      @(posedge clk);
    end
    sym_valid       <= 1'b1;
    sym_data.symbol <= s;
    sym_data.last   <= is_last;
    do @(posedge clk); while (sym_stall);
    bytes_sent++;
  endtask

  task automatic send_string(input logic [lvbr_pkg::SYM_W-1:0] str [$]);
    foreach (str[i]) begin
      send_byte(str[i], i == str.size() - 1);
    end
  endtask

  task automatic hold_until_drained();
    sym_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Mostly bracket runs with stray closes and dangling opens; some raw noise.
  task automatic build_string(ref logic [lvbr_pkg::SYM_W-1:0] str [$]);
    int len;
    int depth;
    str.delete();
    len   = $urandom_range(1, 30);
    depth = 0;
    if ($urandom_range(99) < 25) begin
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(2))
          0: str.push_back(lvbr_pkg::OPEN_SYMBOL);
          1: str.push_back(close_symbol());
          default: str.push_back(lvbr_pkg::SYM_W'($urandom_range(255)));
        endcase
      end
    end else begin
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(9) == 0) begin
          str.push_back(close_symbol());
        end
        if (depth > 0 && (depth >= len - i || $urandom_range(1) == 1)) begin
          str.push_back(close_symbol());
          depth--;
        end else begin
          str.push_back(lvbr_pkg::OPEN_SYMBOL);
          depth++;
        end
      end
    end
  endtask

  initial begin
    logic [lvbr_pkg::SYM_W-1:0] str [$];
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 37;
    recv_idle_pct = 68;
    str = '{lvbr_pkg::OPEN_SYMBOL, 8'h29};
    send_string(str);
    str = '{8'h00, lvbr_pkg::OPEN_SYMBOL, 8'hFF, lvbr_pkg::OPEN_SYMBOL, 8'hA8, 8'h29};
    send_string(str);
    str = '{lvbr_pkg::OPEN_SYMBOL, lvbr_pkg::OPEN_SYMBOL, 8'hD7};
    send_string(str);
    str = '{lvbr_pkg::OPEN_SYMBOL};
    send_string(str);
    str = '{8'h27};
    send_string(str);
    str = '{lvbr_pkg::OPEN_SYMBOL, lvbr_pkg::OPEN_SYMBOL, 8'h08,
            lvbr_pkg::OPEN_SYMBOL, 8'h69, 8'h29};
    send_string(str);
    hold_until_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 68;
        end
        1: begin
          send_idle_pct = 68;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      bytes_sent = 0;
      while (bytes_sent < PHASE_BYTES) begin
        build_string(str);
        send_string(str);
      end
      hold_until_drained();
    end

    sym_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
